>>> rtl/assert_macros.svh
// Assertion macros of the hash set, included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define CHS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/chs_pkg.sv
// Package with constants, codes and controller/datapath interface types of the hash set.
package chs_pkg;

  localparam int DEF_MAX_BUCKETS = 1024;
  localparam int DEF_MAX_ENTRIES = 512;
  localparam int VALUE_W = 32;
  localparam int OUT_W = 24;
  localparam int ADDR_W = 3;
  localparam int LIMIT_W = 4;
  localparam int INIT_W = 11;
  localparam int TOTAL_W = 10;
  localparam int BUCKETS_W = 11;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;
  localparam logic [1:0] OP_FIND_ALT = 2'd3;

  localparam logic REG_LOAD_LIMIT = 1'b0;
  localparam logic REG_INIT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIV_REQ   = 2'd0,
    DIV_ENTRY = 2'd1,
    DIV_PRIME = 2'd2
  } div_src_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_GTEST, S_PCHK, S_PDIV, S_GH, S_GHW, S_GE, S_GEW,
    S_RSTART, S_RG, S_RGW, S_RV, S_RVW, S_RDIV, S_RH, S_RHW,
    S_BDIV, S_BWAIT, S_LH, S_LHW, S_LCHK, S_LCW, S_HIT, S_MISS,
    S_RM2, S_AL, S_ALW, S_INS, S_RES
  } state_t;

  typedef struct packed {
    logic     clr;
    logic     accept;
    logic     prime_init;
    logic     cand_cap;
    logic     cand_next;
    logic     d_next;
    logic     div_start;
    div_src_t div_src;
    logic     head_sel_wb;
    logic     gath_take;
    logic     gath_push;
    logic     gath_link;
    logic     wb_next;
    logic     set_bt;
    logic     rh_take;
    logic     bkt_load;
    logic     rh_commit;
    logic     look_init;
    logic     look_adv;
    logic     res_set;
    logic     res_hit;
    status_t  res_status;
    logic     rm_unlink;
    logic     rm_free;
    logic     alloc_fresh;
    logic     alloc_slot;
    logic     alloc_link;
    logic     ins;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_restart;
    logic clr_last;
    logic is_insert;
    logic is_remove;
    logic grow_need;
    logic cand_over;
    logic dd_over;
    logic div_done;
    logic rem_zero;
    logic head_nil;
    logic link_nil;
    logic cur_nil;
    logic wb_last;
    logic gcnt_zero;
    logic k_last;
    logic match;
    logic full;
    logic fresh_alloc;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/chained_hash_set_core.sv
// Top level of the chained hash set: controller, datapath and assertions.
// One request is taken at a time.
// The bucket remainder comes from a bit-serial unit, which the controller waits on for each value.
// A stored insert adds state S_INS, with S_AL and S_ALW before it when it reuses a freed slot;
// growth adds a prime search by trial division, a pass over the old buckets and a rehash of each entry.
// Reset, and a write of the initial bucket count while idle, start a clearing pass over all MAX_BUCKETS heads.
module chained_hash_set_core #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int MAX_ENTRIES = chs_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [chs_pkg::VALUE_W-1:0]   s_tdata,  // value
  input  logic [1:0]                    s_tuser,  // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [chs_pkg::OUT_W-1:0]     m_tdata   // hit, status, entry_total, buckets_in_use
);
  import chs_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t sts;

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chs_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  `CHS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `CHS_ASSERT_IMPLY(a_hit_status, m_tvalid && m_tdata[0], (m_tdata[2:1] == ST_DONE) || (m_tdata[2:1] == ST_PRESENT), "hit with absent or full status")
  `CHS_ASSERT_IMPLY(a_full_count, m_tvalid && (m_tdata[2:1] == ST_FULL), m_tdata[12:3] == TOTAL_W'(MAX_ENTRIES), "full status below capacity")

endmodule

>>> rtl/chs_divider.sv
// Bit-serial remainder unit with an optional signed, non-negative result.
module chs_divider #(
  parameter int DW = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          signed_mode,
  input  logic [chs_pkg::VALUE_W-1:0]   dividend,
  input  logic [DW-1:0]                 divisor,
  output logic                          done,
  output logic [DW-1:0]                 remainder
);
  import chs_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] sh;
  logic [DW-1:0]      r;
  logic [DW-1:0]      dvs;
  logic               neg;
  logic               neg_in;
  logic [DW:0]        trial;
  logic [DW:0]        diff;

  assign neg_in = signed_mode & dividend[VALUE_W-1];
  assign trial = {r, sh[VALUE_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign remainder = (neg && (r != '0)) ? (dvs - r) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        sh <= neg_in ? (~dividend + 1'b1) : dividend;
        r <= '0;
        dvs <= divisor;
        neg <= neg_in;
      end else if (busy) begin
        sh <= {sh[VALUE_W-2:0], 1'b0};
        r <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/chs_ctrl.sv
// Controller state machine that sequences lookups, updates and table growth.
module chs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  chs_pkg::dp_status_t sts,
  output chs_pkg::dp_cmd_t    cmd
);
  import chs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (sts.cfg_restart) begin
          state_next = S_CLEAR;
        end else if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_GTEST;
        end
      end
      S_GTEST: begin
        if (sts.is_insert && sts.grow_need) begin
          cmd.prime_init = 1'b1;
          state_next = S_PCHK;
        end else begin
          state_next = S_BDIV;
        end
      end
      S_PCHK: begin
        if (sts.cand_over) begin
          cmd.cand_cap = 1'b1;
          state_next = S_GH;
        end else if (sts.dd_over) begin
          state_next = S_GH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src = DIV_PRIME;
          state_next = S_PDIV;
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) cmd.cand_next = 1'b1;
          else cmd.d_next = 1'b1;
          state_next = S_PCHK;
        end
      end
      S_GH: begin
        cmd.head_sel_wb = 1'b1;
        state_next = S_GHW;
      end
      S_GHW: begin
        cmd.head_sel_wb = 1'b1;
        cmd.gath_take = 1'b1;
        if (!sts.head_nil) begin
          state_next = S_GE;
        end else if (sts.wb_last) begin
          state_next = S_RSTART;
        end else begin
          cmd.wb_next = 1'b1;
          state_next = S_GH;
        end
      end
      S_GE: begin
        cmd.gath_push = 1'b1;
        state_next = S_GEW;
      end
      S_GEW: begin
        cmd.gath_link = 1'b1;
        if (!sts.link_nil) begin
          state_next = S_GE;
        end else if (sts.wb_last) begin
          state_next = S_RSTART;
        end else begin
          cmd.wb_next = 1'b1;
          state_next = S_GH;
        end
      end
      S_RSTART: begin
        cmd.set_bt = 1'b1;
        state_next = sts.gcnt_zero ? S_BDIV : S_RG;
      end
      S_RG: state_next = S_RGW;
      S_RGW: begin
        cmd.rh_take = 1'b1;
        state_next = S_RV;
      end
      S_RV: state_next = S_RVW;
      S_RVW: begin
        cmd.div_start = 1'b1;
        cmd.div_src = DIV_ENTRY;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.bkt_load = 1'b1;
          state_next = S_RH;
        end
      end
      S_RH: state_next = S_RHW;
      S_RHW: begin
        cmd.rh_commit = 1'b1;
        state_next = sts.k_last ? S_BDIV : S_RG;
      end
      S_BDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src = DIV_REQ;
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        if (sts.div_done) begin
          cmd.bkt_load = 1'b1;
          state_next = S_LH;
        end
      end
      S_LH: state_next = S_LHW;
      S_LHW: begin
        cmd.look_init = 1'b1;
        state_next = S_LCHK;
      end
      S_LCHK: state_next = sts.cur_nil ? S_MISS : S_LCW;
      S_LCW: begin
        if (sts.match) begin
          state_next = S_HIT;
        end else begin
          cmd.look_adv = 1'b1;
          state_next = S_LCHK;
        end
      end
      S_HIT: begin
        cmd.res_set = 1'b1;
        cmd.res_hit = 1'b1;
        if (sts.is_insert) begin
          cmd.res_status = ST_PRESENT;
          state_next = S_RES;
        end else if (sts.is_remove) begin
          cmd.res_status = ST_DONE;
          cmd.rm_unlink = 1'b1;
          state_next = S_RM2;
        end else begin
          cmd.res_status = ST_DONE;
          state_next = S_RES;
        end
      end
      S_RM2: begin
        cmd.rm_free = 1'b1;
        state_next = S_RES;
      end
      S_MISS: begin
        cmd.res_set = 1'b1;
        if (!sts.is_insert) begin
          cmd.res_status = ST_ABSENT;
          state_next = S_RES;
        end else if (sts.full) begin
          cmd.res_status = ST_FULL;
          state_next = S_RES;
        end else if (sts.fresh_alloc) begin
          cmd.res_status = ST_DONE;
          cmd.alloc_fresh = 1'b1;
          state_next = S_INS;
        end else begin
          cmd.res_status = ST_DONE;
          cmd.alloc_slot = 1'b1;
          state_next = S_AL;
        end
      end
      S_AL: state_next = S_ALW;
      S_ALW: begin
        cmd.alloc_link = 1'b1;
        state_next = S_INS;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

>>> rtl/chs_datapath.sv
// Datapath with bucket and entry memories, set registers, remainder unit and register port.
module chs_datapath #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int MAX_ENTRIES = chs_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic [chs_pkg::VALUE_W-1:0]   s_tdata,
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [chs_pkg::OUT_W-1:0]     m_tdata,
  input  chs_pkg::dp_cmd_t              cmd,
  output chs_pkg::dp_status_t           sts
);
  import chs_pkg::*;

  localparam int BIW = $clog2(MAX_BUCKETS);
  localparam int BTW = $clog2(MAX_BUCKETS + 1);
  localparam int SIW = $clog2(MAX_ENTRIES);
  localparam int SLW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = BTW + 2;
  localparam int GW = SLW + BTW + LIMIT_W;
  localparam int DDW = 2 * BTW;
  localparam logic [SLW-1:0] NIL = SLW'(MAX_ENTRIES);

  logic [SLW-1:0]     heads [MAX_BUCKETS];
  logic [VALUE_W-1:0] values [MAX_ENTRIES];
  logic [SLW-1:0]     links [MAX_ENTRIES];
  logic [SLW-1:0]     gather [MAX_ENTRIES];

  logic [LIMIT_W-1:0] load_limit;
  logic [INIT_W-1:0]  init_count;
  logic [BIW-1:0]     cidx;
  logic [1:0]         op;
  logic [VALUE_W-1:0] val;
  logic [BTW-1:0]     bt;
  logic [SLW-1:0]     stored;
  logic [SLW-1:0]     free_head;
  logic [SLW-1:0]     fresh;
  logic [CW-1:0]      cand;
  logic [BTW-1:0]     d;
  logic [BTW-1:0]     wb;
  logic [BTW-1:0]     bkt;
  logic [SLW-1:0]     gcnt;
  logic [SLW-1:0]     k;
  logic [SLW-1:0]     cur;
  logic [SLW-1:0]     prev;
  logic               hit;
  status_t            status;
  logic               out_valid;
  logic [OUT_W-1:0]   out_data;

  logic [SLW-1:0]     head_q;
  logic [SLW-1:0]     link_q;
  logic [VALUE_W-1:0] value_q;
  logic [SLW-1:0]     gather_q;

  logic               head_we;
  logic [BIW-1:0]     head_wa;
  logic [SLW-1:0]     head_wd;
  logic [BIW-1:0]     head_ra;
  logic               link_we;
  logic [SIW-1:0]     link_wa;
  logic [SLW-1:0]     link_wd;

  logic               cfg_wr;
  logic [BTW-1:0]     bt_clamped;
  logic [GW-1:0]      load_lhs;
  logic [GW-1:0]      load_rhs;
  logic [DDW-1:0]     d_sq;

  logic [VALUE_W-1:0] div_dividend;
  logic [BTW-1:0]     div_divisor;
  logic               div_signed;
  logic               div_done;
  logic [BTW-1:0]     div_rem;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_INIT_COUNT) ? 32'(init_count) : 32'(load_limit);

  always_comb begin
    if (init_count == '0) begin
      bt_clamped = BTW'(1);
    end else if (32'(init_count) > 32'(MAX_BUCKETS)) begin
      bt_clamped = BTW'(MAX_BUCKETS);
    end else begin
      bt_clamped = BTW'(init_count);
    end
  end

  assign load_lhs = GW'(stored) * GW'(10);
  assign load_rhs = GW'(load_limit) * GW'(bt);
  assign d_sq = DDW'(d) * DDW'(d);

  always_comb begin
    case (cmd.div_src)
      DIV_ENTRY: begin
        div_dividend = value_q;
        div_divisor = bt;
        div_signed = 1'b1;
      end
      DIV_PRIME: begin
        div_dividend = VALUE_W'(cand);
        div_divisor = d;
        div_signed = 1'b0;
      end
      default: begin
        div_dividend = val;
        div_divisor = bt;
        div_signed = 1'b1;
      end
    endcase
  end

  chs_divider #(.DW(BTW)) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .signed_mode (div_signed),
    .dividend    (div_dividend),
    .divisor     (div_divisor),
    .done        (div_done),
    .remainder   (div_rem)
  );

  always_comb begin
    head_we = 1'b0;
    head_wa = cidx;
    head_wd = NIL;
    if (cmd.clr) begin
      head_we = 1'b1;
    end else if (cmd.gath_take) begin
      head_we = 1'b1;
      head_wa = wb[BIW-1:0];
    end else if (cmd.rh_commit || cmd.ins) begin
      head_we = 1'b1;
      head_wa = bkt[BIW-1:0];
      head_wd = cur;
    end else if (cmd.rm_unlink && (prev == NIL)) begin
      head_we = 1'b1;
      head_wa = bkt[BIW-1:0];
      head_wd = link_q;
    end
  end

  assign head_ra = cmd.head_sel_wb ? wb[BIW-1:0] : bkt[BIW-1:0];

  always_comb begin
    link_we = 1'b0;
    link_wa = cur[SIW-1:0];
    link_wd = head_q;
    if (cmd.rh_commit || cmd.ins) begin
      link_we = 1'b1;
    end else if (cmd.rm_unlink && (prev != NIL)) begin
      link_we = 1'b1;
      link_wa = prev[SIW-1:0];
      link_wd = link_q;
    end else if (cmd.rm_free) begin
      link_we = 1'b1;
      link_wd = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) heads[head_wa] <= head_wd;
    head_q <= heads[head_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) links[link_wa] <= link_wd;
    link_q <= links[cur[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) values[cur[SIW-1:0]] <= val;
    value_q <= values[cur[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.gath_push) gather[gcnt[SIW-1:0]] <= cur;
    gather_q <= gather[k[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_W'(7);
      init_count <= INIT_W'(6);
      cidx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_LOAD_LIMIT: load_limit <= pwdata[LIMIT_W-1:0];
          REG_INIT_COUNT: init_count <= pwdata[INIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        cidx <= sts.clr_last ? '0 : cidx + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      free_head <= '0;
      fresh <= '0;
      stored <= '0;
      bt <= bt_clamped;
    end
    if (cmd.accept) begin
      op <= s_tuser;
      val <= s_tdata;
    end
    if (cmd.prime_init) begin
      cand <= CW'({bt, 1'b1});
      d <= BTW'(3);
      wb <= '0;
      gcnt <= '0;
      k <= '0;
    end
    if (cmd.cand_cap) cand <= CW'(MAX_BUCKETS);
    if (cmd.cand_next) begin
      cand <= cand + CW'(2);
      d <= BTW'(3);
    end
    if (cmd.d_next) d <= d + BTW'(2);
    if (cmd.gath_take) cur <= head_q;
    if (cmd.gath_push) gcnt <= gcnt + 1'b1;
    if (cmd.gath_link) cur <= link_q;
    if (cmd.wb_next) wb <= wb + 1'b1;
    if (cmd.set_bt) bt <= cand[BTW-1:0];
    if (cmd.rh_take) cur <= gather_q;
    if (cmd.bkt_load) bkt <= div_rem;
    if (cmd.rh_commit) k <= k + 1'b1;
    if (cmd.look_init) begin
      cur <= head_q;
      prev <= NIL;
    end
    if (cmd.look_adv) begin
      prev <= cur;
      cur <= link_q;
    end
    if (cmd.res_set) begin
      hit <= cmd.res_hit;
      status <= cmd.res_status;
    end
    if (cmd.rm_free) begin
      free_head <= cur;
      if (stored != '0) stored <= stored - 1'b1;
    end
    if (cmd.alloc_fresh) begin
      cur <= free_head;
      free_head <= free_head + 1'b1;
      fresh <= fresh + 1'b1;
    end
    if (cmd.alloc_slot) cur <= free_head;
    if (cmd.alloc_link) free_head <= link_q;
    if (cmd.ins) stored <= stored + 1'b1;
    if (cmd.out_load) begin
      out_data <= {BUCKETS_W'(bt), TOTAL_W'(stored), status, hit};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  always_comb begin
    sts.cfg_restart = cfg_wr && (paddr[2] == REG_INIT_COUNT);
    sts.clr_last = (cidx == BIW'(MAX_BUCKETS - 1));
    sts.is_insert = (op == OP_INSERT);
    sts.is_remove = (op == OP_REMOVE);
    sts.grow_need = (load_lhs >= load_rhs) && (bt < BTW'(MAX_BUCKETS));
    sts.cand_over = (cand > CW'(MAX_BUCKETS));
    sts.dd_over = (d_sq > DDW'(cand));
    sts.div_done = div_done;
    sts.rem_zero = (div_rem == '0);
    sts.head_nil = (head_q == NIL);
    sts.link_nil = (link_q == NIL);
    sts.cur_nil = (cur == NIL);
    sts.wb_last = (wb == (bt - 1'b1));
    sts.gcnt_zero = (gcnt == '0);
    sts.k_last = (k == (gcnt - 1'b1));
    sts.match = (value_q == val);
    sts.full = (stored >= SLW'(MAX_ENTRIES));
    sts.fresh_alloc = (free_head == fresh);
    sts.out_free = !out_valid || m_tready;
  end

endmodule

>>> dv/chained_hash_set_core_tb.sv
// Self-checking testbench of the chained hash set core with a built-in set predictor.
`timescale 1ns / 1ps
module chained_hash_set_core_tb;
  import chs_pkg::*;

  localparam int NB = DEF_MAX_BUCKETS;
  localparam int NE = DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [ADDR_W-1:0] ADDR_LOAD_LIMIT = {REG_LOAD_LIMIT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_INIT_COUNT = {REG_INIT_COUNT, 2'b00};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic [BUCKETS_W-1:0] buckets_in_use;
    logic [TOTAL_W-1:0]   entry_total;
    status_t              status;
    logic                 hit;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  chained_hash_set_core i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted set contents, kept as bucket lists, each new member pushed at the front.
  int unsigned limit_tenths;
  int unsigned start_buckets;
  int unsigned bucket_count;
  int unsigned member_count;
  logic [31:0] bucket_list [NB][$];

  request_t request_queue [$];
  outcome_t outcome_queue [$];
  int errors = 0;
  int cycles = 0;
  bit hold_sink = 1'b0;
  bit pause_source = 1'b0;
  int source_wait = 0;
  int sink_wait = 0;

  function automatic int unsigned bucket_index(logic [31:0] v, int unsigned n);
    longint sv;
    longint r;
    sv = longint'(signed'(v));
    r = sv % longint'(n);
    if (r < 0) r += n;
    return 32'(r);
  endfunction

  function automatic bit prime(int unsigned n);
    if (n < 2) return 0;
    if (n == 2) return 1;
    if (n % 2 == 0) return 0;
    for (int unsigned d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 0;
    return 1;
  endfunction

  function automatic void empty_set();
    for (int b = 0; b < NB; b++) bucket_list[b].delete();
    member_count = 0;
    bucket_count = (start_buckets < 1) ? 1 : (start_buckets > NB) ? NB : start_buckets;
  endfunction

  // Rehash walks old buckets in order, each chain head first, and pushes to new heads.
  function automatic void grow_table();
    int unsigned cand;
    logic [31:0] order [$];
    if (bucket_count >= NB) return;
    cand = 2 * bucket_count + 1;
    while (cand <= NB && !prime(cand)) cand += 2;
    if (cand > NB) cand = NB;
    for (int b = 0; b < bucket_count; b++) begin
      foreach (bucket_list[b][k]) order.push_back(bucket_list[b][k]);
      bucket_list[b].delete();
    end
    bucket_count = cand;
    foreach (order[k]) bucket_list[bucket_index(order[k], cand)].push_front(order[k]);
  endfunction

  function automatic outcome_t apply_request(request_t rq);
    outcome_t o;
    int unsigned b;
    int pos;
    o.hit = 1'b0;
    o.status = ST_DONE;
    if (rq.opcode == OP_INSERT &&
        longint'(member_count) * 10 >= longint'(limit_tenths) * bucket_count)
      grow_table();
    b = bucket_index(rq.value, bucket_count);
    pos = -1;
    foreach (bucket_list[b][k])
      if (pos < 0 && bucket_list[b][k] == rq.value) pos = k;
    if (rq.opcode == OP_INSERT) begin
      if (pos >= 0) begin
        o.hit = 1'b1;
        o.status = ST_PRESENT;
      end else if (member_count >= NE) begin
        o.status = ST_FULL;
      end else begin
        bucket_list[b].push_front(rq.value);
        member_count++;
      end
    end else if (rq.opcode == OP_REMOVE) begin
      if (pos >= 0) begin
        o.hit = 1'b1;
        bucket_list[b].delete(pos);
        member_count--;
      end else begin
        o.status = ST_ABSENT;
      end
    end else begin
      o.hit = pos >= 0;
      o.status = (pos >= 0) ? ST_DONE : ST_ABSENT;
    end
    o.entry_total = TOTAL_W'(member_count);
    o.buckets_in_use = BUCKETS_W'(bucket_count);
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  bit in_taken;
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready && !rst;
  end

  // Driver: one request at a time from the pending queue, with a random gap before each.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        outcome_queue.push_back(apply_request(request_queue.pop_front()));
        source_wait = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) source_wait = 0;
      end
      if (in_taken || !s_tvalid) begin
        if (source_wait > 0 || pause_source || request_queue.size() == 0) begin
          if (source_wait > 0) source_wait--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser <= request_queue[0].opcode;
          s_tdata <= request_queue[0].value;
        end
      end
    end
  end

  // Sampled at the rising edge into these, so the checker sees a settled handshake.
  bit out_taken;
  logic [OUT_W-1:0] out_word;
  always @(posedge clk) begin
    out_taken <= m_tvalid && m_tready && !rst;
    out_word <= m_tdata;
  end

  // Monitor and receiver.
  always @(negedge clk) begin
    outcome_t got, want;
    if (out_taken) begin
      got = outcome_t'(out_word);
      if (outcome_queue.size() == 0) begin
        $error("unexpected result %h", out_word);
        errors++;
      end else begin
        want = outcome_queue.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.entry_total !== want.entry_total) begin
          $error("entry_total expected %0d got %0d", want.entry_total, got.entry_total);
          errors++;
        end
        if (got.buckets_in_use !== want.buckets_in_use) begin
          $error("buckets_in_use expected %0d got %0d", want.buckets_in_use,
                 got.buckets_in_use);
          errors++;
        end
      end
      sink_wait = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) sink_wait = 0;
    end
    if (!rst) begin
      if (out_taken || !m_tready) begin
        if (sink_wait > 0 || hold_sink) begin
          if (sink_wait > 0) sink_wait--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOAD_LIMIT) limit_tenths = data & 32'hF;
    else begin
      start_buckets = data & 32'h7FF;
      empty_set();
    end
  endtask

  task automatic drain();
    while (request_queue.size() != 0 || outcome_queue.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (2 * NB + 200) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(int span);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, span) - span / 2;
    endcase
  endfunction

  task automatic add_random(int count, int span);
    request_t rq;
    repeat (count) begin
      rq.opcode = ($urandom_range(0, 9) < 5) ? OP_INSERT : 2'($urandom_range(1, 3));
      rq.value = pick_value(span);
      request_queue.push_back(rq);
    end
  endtask

  initial begin
    request_t rq;
    limit_tenths = 7;
    start_buckets = 6;
    empty_set();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rq = '{OP_INSERT, 32'h7FFF_FFFF}; request_queue.push_back(rq);
    rq = '{OP_INSERT, 32'h8000_0000}; request_queue.push_back(rq);
    rq = '{OP_INSERT, 32'h0};         request_queue.push_back(rq);
    rq = '{OP_INSERT, 32'hFFFF_FFFF}; request_queue.push_back(rq);
    rq = '{OP_INSERT, 32'h8000_0000}; request_queue.push_back(rq);
    rq = '{OP_FIND, 32'h8000_0000};   request_queue.push_back(rq);
    rq = '{OP_FIND, 32'h1234_5678};   request_queue.push_back(rq);
    rq = '{OP_FIND_ALT, 32'h7FFF_FFFF}; request_queue.push_back(rq);
    rq = '{OP_REMOVE, 32'h0};         request_queue.push_back(rq);
    rq = '{OP_REMOVE, 32'h0};         request_queue.push_back(rq);
    rq = '{OP_REMOVE, 32'hFFFF_FFFF}; request_queue.push_back(rq);
    for (int k = 0; k < 8; k++) begin
      rq = '{OP_INSERT, 32'(k * 6 - 20)};
      request_queue.push_back(rq);
    end
    drain();

    // Several register settings, extremes among them; the sink stalls in one phase.
    write_register(ADDR_LOAD_LIMIT, 1);
    write_register(ADDR_INIT_COUNT, 1);
    add_random(120, 200);
    drain();
    write_register(ADDR_LOAD_LIMIT, 10);
    write_register(ADDR_INIT_COUNT, 1024);
    add_random(100, 4000);
    drain();
    write_register(ADDR_LOAD_LIMIT, 0);
    write_register(ADDR_INIT_COUNT, 0);
    add_random(60, 100);
    drain();
    write_register(ADDR_INIT_COUNT, 2047);
    add_random(40, 100);
    drain();
    write_register(ADDR_LOAD_LIMIT, 4);
    write_register(ADDR_INIT_COUNT, 13);
    add_random(100, 2000);
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(negedge clk);
        hold_sink = 1'b0;
      end
    join_none
    drain();

    // Fill to capacity to reach the full status, then remove 40 of the stored values.
    write_register(ADDR_LOAD_LIMIT, 7);
    write_register(ADDR_INIT_COUNT, 6);
    for (int k = 0; k < 530; k++) begin
      rq = '{OP_INSERT, 32'(k * 7919 - 1000000)};
      request_queue.push_back(rq);
    end
    for (int k = 0; k < 40; k++) begin
      rq = '{OP_REMOVE, 32'(k * 7919 - 1000000)};
      request_queue.push_back(rq);
    end
    drain();
    pause_source = 1'b1;
    repeat (50) @(negedge clk);
    pause_source = 1'b0;
    add_random(100, 500);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
